### rtl/sed_pkg.sv
// shared widths, constants and types for the scaled euclidean distance block
`timescale 1ns / 1ps
`default_nettype none
package sed_pkg;

    localparam int ELEM_W   = 8;
    localparam int SQ_W     = 2 * ELEM_W;
    localparam int SUM_W    = 21;
    localparam int ROOT_W   = 19;
    localparam int SCALE_W  = 16;
    localparam int PROD_W   = ROOT_W + SCALE_W;
    localparam int DIST_W   = 27;
    localparam int FRAC_SH  = 8;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 2;

    localparam int MAX_ELEMENTS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd5033;
    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};

    // finished vector handed from accumulator to root unit
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             overflow;
    } vector_t;

endpackage
`default_nettype wire

### rtl/sed_queue.sv
// small register queue of finished vectors between accumulator and root unit
`timescale 1ns / 1ps
`default_nettype none
module sed_queue #(
    parameter int DEPTH = sed_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  sed_pkg::vector_t     push_data,
    output logic                 full,
    input  wire logic            pop,
    output sed_pkg::vector_t     pop_data,
    output logic                 empty
);
    import sed_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    vector_t          entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### rtl/sed_front.sv
// element pair accumulator: squared differences, pair count, overflow
`timescale 1ns / 1ps
`default_nettype none
module sed_front #(
    parameter int MAX_ELEMENTS = sed_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [sed_pkg::ELEM_W-1:0] first_element,
    input  wire logic [sed_pkg::ELEM_W-1:0] second_element,
    input  wire logic                       last_pair,
    output logic                            push,
    output sed_pkg::vector_t                push_data
);
    import sed_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [ELEM_W-1:0] diff;
    logic [SQ_W-1:0]   sq;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_acc;
    logic [CNT_W-1:0]  count_acc;
    logic              ovf_acc;

    assign diff     = (first_element >= second_element) ? first_element - second_element
                                                        : second_element - first_element;
    assign sq       = SQ_W'(diff) * SQ_W'(diff);
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(sq);

    always_comb
    begin
        // counter saturates at the limit, a further pair marks overflow
        if (count_reg >= MAX_CNT)
        begin
            ovf_acc   = 1'b1;
            count_acc = count_reg;
        end
        else
        begin
            ovf_acc   = ovf_reg;
            count_acc = count_reg + 1'b1;
        end

        if (ovf_acc)
        begin
            sum_acc = SUM_MAX;
        end
        else if (sum_wide[SUM_W])
        begin
            sum_acc = SUM_MAX;
        end
        else
        begin
            sum_acc = sum_wide[SUM_W-1:0];
        end

        push               = accept && last_pair;
        push_data.sum      = sum_acc;
        push_data.overflow = ovf_acc;

        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (last_pair)
            begin
                sum_next   = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                sum_next   = sum_acc;
                count_next = count_acc;
                ovf_next   = ovf_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule
`default_nettype wire

### rtl/sed_back.sv
// root unit: bit-serial square root, scale multiply and output register
`timescale 1ns / 1ps
`default_nettype none
module sed_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        empty,
    input  sed_pkg::vector_t                 pop_data,
    output logic                             pop,
    input  wire logic [sed_pkg::SCALE_W-1:0] scale,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [sed_pkg::SUM_W-1:0]        squared_sum,
    output logic [sed_pkg::ROOT_W-1:0]       root_q8,
    output logic [sed_pkg::DIST_W-1:0]       scaled_distance_q24,
    output logic                             count_overflow
);
    import sed_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROOT = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              ovf_reg, ovf_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              valid_reg, valid_next;
    logic [REM_W+1:0]  rem_shift;
    logic [REM_W+1:0]  trial;

    // one result bit per step: bring down two radicand bits, try 4r+1
    assign rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = (REM_W + 2)'({root_reg, 2'b01});

    assign pop                 = (state_reg == ST_IDLE) && !empty;
    assign out_valid           = valid_reg;
    assign squared_sum         = sum_reg;
    assign root_q8             = root_reg;
    assign scaled_distance_q24 = prod_reg[FRAC_SH +: DIST_W];
    assign count_overflow      = ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        prod_next  = prod_reg;
        valid_next = valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    sum_next   = pop_data.sum;
                    ovf_next   = pop_data.overflow;
                    rad_next   = RAD_W'({pop_data.sum, 16'd0});
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                rad_next = {rad_reg[RAD_W-3:0], 2'b00};
                if (rem_shift >= trial)
                begin
                    rem_next  = REM_W'(rem_shift - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(rem_shift);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(root_reg) * PROD_W'(scale);
                valid_next = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        sum_reg  <= sum_next;
        ovf_reg  <= ovf_next;
        prod_reg <= prod_next;
    end

endmodule
`default_nettype wire

### rtl/scaled_euclidean_distance.sv
// scaled euclidean distance top level: accumulator, vector queue, root unit
// throughput: one element pair per cycle while the vector queue is not full; the
//   bit-serial root unit takes one vector at a time while the queue lets pairs stream on
// reset: rst_n asynchronous active low; clears sum, count, overflow, queue and
//   output valid; scale register returns to 5033 (about 0.0003 in Q0.24)
`timescale 1ns / 1ps
`default_nettype none
module scaled_euclidean_distance #(
    parameter int MAX_ELEMENTS = sed_pkg::MAX_ELEMENTS_DEF,
    parameter int QUEUE_DEPTH  = sed_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration write channel, scale register only
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [sed_pkg::SCALE_W-1:0] cfg_data,
    // element pair input channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [sed_pkg::ELEM_W-1:0]  first_element,
    input  wire logic [sed_pkg::ELEM_W-1:0]  second_element,
    input  wire logic                        last_pair,
    // result channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [sed_pkg::SUM_W-1:0]        squared_sum,
    output logic [sed_pkg::ROOT_W-1:0]       root_q8,
    output logic [sed_pkg::DIST_W-1:0]       scaled_distance_q24,
    output logic                             count_overflow
);
    import sed_pkg::*;

    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic               in_accept;
    logic               push;
    vector_t            push_data;
    logic               queue_full;
    logic               pop;
    vector_t            pop_data;
    logic               queue_empty;

    // scale register is always writable
    assign cfg_ready  = 1'b1;
    assign scale_next = (cfg_valid && cfg_ready) ? cfg_data : scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else
        begin
            scale_reg <= scale_next;
        end
    end

    // pairs stall only while the vector queue is full
    assign in_stall  = queue_full;
    assign in_accept = in_valid && !in_stall;

    // front: running sum of squared differences, closes a vector on the last pair
    sed_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .first_element  (first_element),
        .second_element (second_element),
        .last_pair      (last_pair),
        .push           (push),
        .push_data      (push_data)
    );

    // finished vectors wait here while the root unit is busy
    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    // back: square root with 8 fraction bits, scale multiply, held result
    sed_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .empty               (queue_empty),
        .pop_data            (pop_data),
        .pop                 (pop),
        .scale               (scale_reg),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .squared_sum         (squared_sum),
        .root_q8             (root_q8),
        .scaled_distance_q24 (scaled_distance_q24),
        .count_overflow      (count_overflow)
    );

endmodule
`default_nettype wire
